@@ design/gbic_pkg.sv @@
package gbic_pkg;

	// request codes carried on req_type
	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_READ   = 2'd2,
		REQ_SCAN   = 2'd3
	} req_t;

	// register selects carried on reg_sel
	typedef enum logic [1:0] {
		SEL_MASK   = 2'd0,
		SEL_EDGE   = 2'd1,
		SEL_STATUS = 2'd2,
		SEL_LEVELS = 2'd3
	} sel_t;

	// what the result registers load this cycle
	typedef enum logic [1:0] {
		OUT_NONE  = 2'd0,
		OUT_READ  = 2'd1,
		OUT_EMPTY = 2'd2,
		OUT_LINE  = 2'd3
	} out_sel_t;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned BANK_W = 3;
	localparam int unsigned LINE_W = 8;

	typedef struct packed {
		logic     sample;
		logic     write;
		logic     load_scan;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic pend_zero;
		logic rest_zero;
	} status_t;

endpackage

@@ design/gbic_ctrl.sv @@
module gbic_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       req_type,
	input  gbic_pkg::status_t st,
	output gbic_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             strobe
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t           state_q;
	logic             busy_q;
	logic             strobe_q;
	logic             accept;
	gbic_pkg::req_t   req;

	assign req    = gbic_pkg::req_t'(req_type);
	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign strobe = strobe_q;

	always_comb begin
		cmd = '{sample: 1'b0, write: 1'b0, load_scan: 1'b0,
			out_sel: gbic_pkg::OUT_NONE};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req)
						gbic_pkg::REQ_SAMPLE: cmd.sample = 1'b1;
						gbic_pkg::REQ_WRITE:  cmd.write  = 1'b1;
						gbic_pkg::REQ_READ:   cmd.out_sel = gbic_pkg::OUT_READ;
						gbic_pkg::REQ_SCAN: begin
							if (st.pend_zero)
								cmd.out_sel = gbic_pkg::OUT_EMPTY;
							else
								cmd.load_scan = 1'b1;
						end
						default: cmd.out_sel = gbic_pkg::OUT_NONE;
					endcase
				end
			end
			ST_SCAN: cmd.out_sel = gbic_pkg::OUT_LINE;
			default: cmd.out_sel = gbic_pkg::OUT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.out_sel != gbic_pkg::OUT_NONE);
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_scan) begin
						state_q <= ST_SCAN;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					// leave once the last pending line goes out
					if (st.rest_zero) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	ap_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q == ST_SCAN))
		else $error("busy disagrees with state");

	ap_scan_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_scan |-> state_q == ST_IDLE && !st.pend_zero)
		else $error("scan loaded outside idle or with nothing pending");

	ap_no_update_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !cmd.sample && !cmd.write)
		else $error("bank update while scanning");

endmodule

@@ design/gbic_dp.sv @@
module gbic_dp #(
	parameter int unsigned NUM_BANKS      = 6,
	parameter int unsigned LINES_PER_BANK = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gbic_pkg::cmd_t                  cmd,
	input  logic [gbic_pkg::BANK_W-1:0]     bank,
	input  logic [1:0]                      reg_sel,
	input  logic [gbic_pkg::DATA_W-1:0]     write_data,
	output gbic_pkg::status_t               st,
	output logic [gbic_pkg::DATA_W-1:0]     read_data,
	output logic [gbic_pkg::LINE_W-1:0]     line_number,
	output logic                            line_valid,
	output logic                            last
);

	localparam int unsigned LPB = LINES_PER_BANK;
	localparam int unsigned BW  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int unsigned IW  = $clog2(LINES_PER_BANK);

	logic [LPB-1:0] mask_q   [NUM_BANKS];
	logic [LPB-1:0] edge_q   [NUM_BANKS];
	logic [LPB-1:0] status_q [NUM_BANKS];
	logic [LPB-1:0] level_q  [NUM_BANKS];

	logic [7:0]      bank_ext;
	logic [BW-1:0]   bidx;
	logic            bank_ok;
	logic [LPB-1:0]  data;
	logic [LPB-1:0]  cur_mask, cur_edge, cur_status, cur_level;
	logic [LPB-1:0]  edges;
	logic [LPB-1:0]  pending;
	logic [LPB-1:0]  rd_val;
	gbic_pkg::sel_t  sel;

	logic [LPB-1:0]                pend_q;
	logic [gbic_pkg::BANK_W-1:0]   scan_bank_q;
	logic [LPB-1:0]                low_bit;
	logic [LPB-1:0]                rest;
	logic [IW-1:0]                 idx;
	logic [gbic_pkg::LINE_W-1:0]   line_calc;

	logic [gbic_pkg::DATA_W-1:0]   read_data_q;
	logic [gbic_pkg::LINE_W-1:0]   line_number_q;
	logic                          line_valid_q;
	logic                          last_q;

	assign sel      = gbic_pkg::sel_t'(reg_sel);
	assign bank_ext = {5'd0, bank};
	assign bidx     = bank_ext[BW-1:0];
	assign bank_ok  = ({2'b00, bank} < 5'(NUM_BANKS));
	assign data     = write_data[LPB-1:0];

	always_comb begin
		if (bank_ok) begin
			cur_mask   = mask_q[bidx];
			cur_edge   = edge_q[bidx];
			cur_status = status_q[bidx];
			cur_level  = level_q[bidx];
		end else begin
			cur_mask   = '1;
			cur_edge   = '0;
			cur_status = '0;
			cur_level  = '0;
		end
	end

	// rising edges where edge select is one, falling where it is zero
	assign edges   = (cur_edge & ~cur_level & data) | (~cur_edge & cur_level & ~data);
	assign pending = cur_status |
		(~cur_mask & ((cur_edge & cur_level) | ~(cur_edge | cur_level)));

	always_comb begin
		case (sel)
			gbic_pkg::SEL_MASK:   rd_val = cur_mask;
			gbic_pkg::SEL_EDGE:   rd_val = cur_edge;
			gbic_pkg::SEL_STATUS: rd_val = cur_status;
			gbic_pkg::SEL_LEVELS: rd_val = cur_level;
			default:              rd_val = '0;
		endcase
		if (!bank_ok)
			rd_val = '0;
	end

	// isolate the lowest pending bit and encode it
	assign low_bit = pend_q & (~pend_q + LPB'(1));
	assign rest    = pend_q & ~low_bit;

	always_comb begin
		idx = '0;
		for (int i = 0; i < LPB; i++) begin
			idx = idx | (low_bit[i] ? IW'(i) : IW'(0));
		end
	end

	// line numbers come from the bank captured with the snapshot
	assign line_calc = 8'({5'd0, scan_bank_q} * 8'(LINES_PER_BANK)) + 8'(idx);

	assign st.pend_zero = (pending == '0);
	assign st.rest_zero = (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANKS; b++) begin
				mask_q[b]   <= '1;
				edge_q[b]   <= '0;
				status_q[b] <= '0;
				level_q[b]  <= '0;
			end
		end else if (bank_ok) begin
			if (cmd.sample) begin
				status_q[bidx] <= cur_status | (edges & ~cur_mask);
				level_q[bidx]  <= data;
			end else if (cmd.write) begin
				case (sel)
					gbic_pkg::SEL_MASK:   mask_q[bidx]   <= data;
					gbic_pkg::SEL_EDGE:   edge_q[bidx]   <= data;
					gbic_pkg::SEL_STATUS: status_q[bidx] <= cur_status & ~data;
					default: ;
				endcase
			end
		end
	end

	// scan snapshot and result payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_scan) begin
			pend_q      <= pending;
			scan_bank_q <= bank;
		end else if (cmd.out_sel == gbic_pkg::OUT_LINE) begin
			pend_q <= rest;
		end
		case (cmd.out_sel)
			gbic_pkg::OUT_READ: begin
				read_data_q   <= 32'(rd_val);
				line_number_q <= '0;
				line_valid_q  <= 1'b0;
				last_q        <= 1'b1;
			end
			gbic_pkg::OUT_EMPTY: begin
				read_data_q   <= '0;
				line_number_q <= '0;
				line_valid_q  <= 1'b0;
				last_q        <= 1'b1;
			end
			gbic_pkg::OUT_LINE: begin
				read_data_q   <= '0;
				line_number_q <= line_calc;
				line_valid_q  <= 1'b1;
				last_q        <= (rest == '0);
			end
			default: ;
		endcase
	end

	assign read_data   = read_data_q;
	assign line_number = line_number_q;
	assign line_valid  = line_valid_q;
	assign last        = last_q;

endmodule

@@ design/gpio_bank_interrupt_controller_unit.sv @@
// Channel   Handshake            Ports
// -------   ------------------   -------------------------------------------
// request   start & !busy        req_type, bank, reg_sel, write_data
// result    strobe (one cycle)   read_data, line_number, line_valid, last
//
// A pin sample or register write gives no result; busy stays low so the
// next request can follow at once.
// A register read, or a scan with nothing pending, shows its result on the
// cycle after acceptance.
// A scan holds busy while the lowest-set-bit encoder steps through the
// snapshot, giving one pending line a cycle.
// Reset (arst_n low) sets every mask bit and clears edge select, status
// and levels; the receiver cannot stall, so results never wait.
module gpio_bank_interrupt_controller_unit #(
	parameter int unsigned NUM_BANKS      = 6,
	parameter int unsigned LINES_PER_BANK = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      req_type,
	input  logic [gbic_pkg::BANK_W-1:0]     bank,
	input  logic [1:0]                      reg_sel,
	input  logic [gbic_pkg::DATA_W-1:0]     write_data,
	output logic                            strobe,
	output logic [gbic_pkg::DATA_W-1:0]     read_data,
	output logic [gbic_pkg::LINE_W-1:0]     line_number,
	output logic                            line_valid,
	output logic                            last
);

	gbic_pkg::cmd_t    cmd;
	gbic_pkg::status_t st;

	// sequence each request: idle, or step through a scan snapshot
	gbic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy),
		.strobe   (strobe)
	);

	// hold the bank registers, latch edges, encode pending lines
	gbic_dp #(
		.NUM_BANKS      (NUM_BANKS),
		.LINES_PER_BANK (LINES_PER_BANK)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.bank        (bank),
		.reg_sel     (reg_sel),
		.write_data  (write_data),
		.st          (st),
		.read_data   (read_data),
		.line_number (line_number),
		.line_valid  (line_valid),
		.last        (last)
	);

	// entering a scan never coincides with a result going out
	ap_rise_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !strobe)
		else $error("result shown as scan began");

	// leaving a scan coincides with its final line
	ap_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last && line_valid)
		else $error("scan ended without its last line");

	// a scan's lines come without gaps until last
	ap_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a scan burst");

	// only pending lines can be non-final
	ap_mid_valid: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> line_valid && busy)
		else $error("non-final result without a line");

endmodule
